>>> rtl/core/dilp_pkg.sv
// ----------------------------------------------------------------------------
// dilp_pkg
// Types, constants and codes shared by the delimited integer list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dilp_pkg;

    localparam int CH_W     = 8;
    localparam int MAXC_W   = 13;
    localparam int IDX_W    = 12;
    localparam int VAL_W    = 32;
    localparam int MAG_W    = 64;
    localparam int DIGIT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAXC_W-1:0] CAP_LIMIT       = 13'd4096;
    localparam logic [MAXC_W-1:0] MAX_COUNT_RESET = 13'd16;
    localparam logic [CH_W-1:0]   DELIMITER_RESET = 8'd44;
    localparam logic [MAG_W-1:0]  SAT_TENTH       = 64'd922337203685477580;
    localparam logic [DIGIT_W-1:0] LAST_SAFE_DIGIT = 4'd8;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_DELIM,
        OP_TERM
    } t_op_kind;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_INVALID
    } t_status;

    // Classified character, as queued between front and back
    typedef struct packed {
        t_op_kind           kind;
        logic               is_digit;
        logic               is_space;
        logic               is_sign;
        logic               is_minus;
        logic [DIGIT_W-1:0] digit;
    } t_op;

endpackage

`default_nettype wire

>>> rtl/core/dilp_front.sv
// ----------------------------------------------------------------------------
// dilp_front
// Accepts characters and classifies them for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module dilp_front
    import dilp_pkg::*;
(
    input  wire logic            i_valid,
    input  wire logic [CH_W-1:0] i_ch,
    input  wire logic [CH_W-1:0] i_delimiter,
    input  wire logic            i_queue_full,
    output logic                 o_stall,
    output logic                 o_push,
    output t_op                  o_op
);

    logic [CH_W-1:0] w_digit_off;

    assign o_stall     = i_queue_full;
    assign o_push      = i_valid && !i_queue_full;
    assign w_digit_off = i_ch - CH_ZERO;

    always_comb begin
        o_op          = '0;
        // zero byte terminates even when it is also the delimiter
        if (i_ch == CH_NUL) begin
            o_op.kind = OP_TERM;
        end else if (i_ch == i_delimiter) begin
            o_op.kind = OP_DELIM;
        end else begin
            o_op.kind = OP_CHAR;
        end
        o_op.is_digit = i_ch inside {[CH_ZERO:CH_NINE]};
        o_op.is_space = (i_ch == CH_SPACE) || (i_ch inside {[CH_TAB:CH_CR]});
        o_op.is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
        o_op.is_minus = (i_ch == CH_MINUS);
        o_op.digit    = w_digit_off[DIGIT_W-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/core/dilp_queue.sv
// ----------------------------------------------------------------------------
// dilp_queue
// Short first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
`default_nettype none

module dilp_queue
    import dilp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_op       o_op,
    output logic [QLVL_W-1:0] o_level
);

    t_op                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QLVL_W-1:0]  r_level, n_level;

    assign o_full  = (r_level == QLVL_W'(QUEUE_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_op    = r_mem[r_rptr];
    assign o_level = r_level;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (i_pop && !i_push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dilp_back.sv
// ----------------------------------------------------------------------------
// dilp_back
// Runs the field scanner and accumulator, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dilp_back
    import dilp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [MAXC_W-1:0] i_max_count,
    input  wire logic              i_empty,
    input  wire t_op               i_op,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic                   o_value_valid,
    output logic signed [VAL_W-1:0] o_value,
    output logic [IDX_W-1:0]       o_value_index,
    output logic                   o_done_res,
    output logic [STATUS_W-1:0]    o_status,
    output logic [MAXC_W-1:0]      o_count
);

    // per-string state
    logic               r_nonempty, n_nonempty;
    t_phase             r_phase, n_phase;
    logic               r_negative, n_negative;
    logic [MAG_W-1:0]   r_mag, n_mag;
    logic               r_sat, n_sat;
    logic [MAXC_W-1:0]  r_count, n_count;
    t_status            r_err, n_err;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_o_value_valid, n_o_value_valid;
    logic [VAL_W-1:0]   r_o_value, n_o_value;
    logic [IDX_W-1:0]   r_o_index, n_o_index;
    logic               r_o_done, n_o_done;
    t_status            r_o_status, n_o_status;
    logic [MAXC_W-1:0]  r_o_count, n_o_count;

    logic [MAXC_W-1:0]  w_cap;
    logic               w_end_given;
    t_status            w_end_err;
    t_status            w_term_err;
    logic [MAXC_W-1:0]  w_end_count;
    logic [VAL_W-1:0]   w_field_val;
    logic [MAG_W-1:0]   w_mag_acc;
    logic               w_overflow_next;
    logic               w_live;

    assign o_pop  = !i_empty && (!r_out_valid || !i_stall);
    assign w_live = (r_err == ST_OK);
    assign w_cap  = (i_max_count > CAP_LIMIT) ? CAP_LIMIT : i_max_count;

    // mag * 10 + d, only used while mag <= SAT_TENTH
    assign w_mag_acc = {r_mag[MAG_W-4:0], 3'b000} + {r_mag[MAG_W-2:0], 1'b0}
                     + MAG_W'(i_op.digit);
    assign w_overflow_next = (r_mag > SAT_TENTH)
                          || ((r_mag == SAT_TENTH) && (i_op.digit > LAST_SAFE_DIGIT));

    // saturate at the 64-bit limits; bit 63 set means at or beyond 2^63
    always_comb begin
        if (r_sat || r_mag[MAG_W-1]) begin
            w_field_val = r_negative ? '0 : '1;
        end else if (r_negative) begin
            w_field_val = '0 - r_mag[VAL_W-1:0];
        end else begin
            w_field_val = r_mag[VAL_W-1:0];
        end
    end

    // closing a field
    always_comb begin
        w_end_given = 1'b0;
        w_end_err   = r_err;
        w_end_count = r_count;
        if (r_nonempty && w_live) begin
            if (w_cap == '0) begin
                w_end_err = ST_INVALID;
            end else if (r_count >= w_cap) begin
                w_end_err = ST_OVERFLOW;
            end else begin
                w_end_given = 1'b1;
                w_end_count = r_count + 1'b1;
            end
        end
        w_term_err = w_end_err;
        if (w_end_err == ST_OK && i_max_count == '0) begin
            w_term_err = ST_INVALID;
        end
    end

    // scan phase next state
    always_comb begin
        n_phase = r_phase;
        if (o_pop) begin
            case (i_op.kind)
                OP_TERM: begin
                    n_phase = PH_SKIP;
                end
                OP_DELIM: begin
                    if (w_live) begin
                        n_phase = PH_SKIP;
                    end
                end
                OP_CHAR: begin
                    if (w_live && r_phase != PH_STOP) begin
                        if (i_op.is_digit) begin
                            n_phase = PH_DIGITS;
                        end else if (r_phase == PH_SKIP && i_op.is_space) begin
                            n_phase = PH_SKIP;
                        end else if (r_phase == PH_SKIP && i_op.is_sign) begin
                            n_phase = PH_SIGNED;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_nonempty      = r_nonempty;
        n_negative      = r_negative;
        n_mag           = r_mag;
        n_sat           = r_sat;
        n_count         = r_count;
        n_err           = r_err;
        n_out_valid     = r_out_valid && i_stall;
        n_o_value_valid = r_o_value_valid;
        n_o_value       = r_o_value;
        n_o_index       = r_o_index;
        n_o_done        = r_o_done;
        n_o_status      = r_o_status;
        n_o_count       = r_o_count;
        if (o_pop) begin
            case (i_op.kind)
                OP_TERM: begin
                    n_out_valid     = 1'b1;
                    n_o_value_valid = w_end_given;
                    n_o_value       = w_end_given ? w_field_val : '0;
                    n_o_index       = w_end_given ? r_count[IDX_W-1:0] : '0;
                    n_o_done        = 1'b1;
                    n_o_status      = w_term_err;
                    n_o_count       = w_end_count;
                    n_nonempty      = 1'b0;
                    n_negative      = 1'b0;
                    n_mag           = '0;
                    n_sat           = 1'b0;
                    n_count         = '0;
                    n_err           = ST_OK;
                end
                OP_DELIM: begin
                    if (w_live) begin
                        n_err       = w_end_err;
                        n_count     = w_end_count;
                        n_nonempty  = 1'b0;
                        n_negative  = 1'b0;
                        n_mag       = '0;
                        n_sat       = 1'b0;
                        if (w_end_given) begin
                            n_out_valid     = 1'b1;
                            n_o_value_valid = 1'b1;
                            n_o_value       = w_field_val;
                            n_o_index       = r_count[IDX_W-1:0];
                            n_o_done        = 1'b0;
                            n_o_status      = ST_OK;
                            n_o_count       = '0;
                        end
                    end
                end
                OP_CHAR: begin
                    if (w_live) begin
                        n_nonempty = 1'b1;
                        if (r_phase != PH_STOP) begin
                            if (i_op.is_digit) begin
                                if (!r_sat) begin
                                    if (w_overflow_next) begin
                                        n_sat = 1'b1;
                                    end else begin
                                        n_mag = w_mag_acc;
                                    end
                                end
                            end else if (r_phase == PH_SKIP && !i_op.is_space
                                         && i_op.is_sign) begin
                                n_negative = i_op.is_minus;
                            end
                        end
                    end
                end
                default: begin
                    n_err = r_err;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty  <= 1'b0;
            r_phase     <= PH_SKIP;
            r_negative  <= 1'b0;
            r_mag       <= '0;
            r_sat       <= 1'b0;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_nonempty  <= n_nonempty;
            r_phase     <= n_phase;
            r_negative  <= n_negative;
            r_mag       <= n_mag;
            r_sat       <= n_sat;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_value_valid <= n_o_value_valid;
        r_o_value       <= n_o_value;
        r_o_index       <= n_o_index;
        r_o_done        <= n_o_done;
        r_o_status      <= n_o_status;
        r_o_count       <= n_o_count;
    end

    assign o_valid       = r_out_valid;
    assign o_value_valid = r_o_value_valid;
    assign o_value       = r_o_value;
    assign o_value_index = r_o_index;
    assign o_done_res    = r_o_done;
    assign o_status      = r_o_status;
    assign o_count       = r_o_count;

endmodule

`default_nettype wire

>>> rtl/core/delimited_integer_list_parser.sv
// ----------------------------------------------------------------------------
// delimited_integer_list_parser
// Splits a zero-terminated byte stream at a delimiter and converts each
// non-empty field to a decimal integer.
// ----------------------------------------------------------------------------
// One character is accepted per clock cycle while the queue is not full. A
// character is classified on entry and placed in a two-entry queue; the
// execution side takes one queued character per cycle while the output is
// not held, updating the 64-bit accumulator with a single multiply-by-ten
// add, and writes any result to an output register. i_stall on the
// output holds the execution side; the input stalls only once the queue is
// full. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and must
// only change while no string is in flight.
`default_nettype none

module delimited_integer_list_parser
    import dilp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [MAXC_W-1:0]     i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [CH_W-1:0]       i_ch,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_value_valid,
    output logic signed [VAL_W-1:0]    o_value,
    output logic [IDX_W-1:0]           o_value_index,
    output logic                       o_done_res,
    output logic [STATUS_W-1:0]        o_status,
    output logic [MAXC_W-1:0]          o_count
);

    logic [CH_W-1:0]    r_delimiter;
    logic [MAXC_W-1:0]  r_max_count;

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    t_op                w_op_in;
    t_op                w_op_out;
    logic [QLVL_W-1:0]  w_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter <= DELIMITER_RESET;
            r_max_count <= MAX_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DELIMITER: r_delimiter <= i_cfg_data[CH_W-1:0];
                REG_MAX_COUNT: r_max_count <= i_cfg_data;
                default: r_delimiter <= r_delimiter;
            endcase
        end
    end

    dilp_front u_front (
        .i_valid      (i_valid),
        .i_ch         (i_ch),
        .i_delimiter  (r_delimiter),
        .i_queue_full (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_op         (w_op_in)
    );

    dilp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_op    (w_op_out),
        .o_level (w_level)
    );

    dilp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_count   (r_max_count),
        .i_empty       (w_empty),
        .i_op          (w_op_out),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_value_valid (o_value_valid),
        .o_value       (o_value),
        .o_value_index (o_value_index),
        .o_done_res    (o_done_res),
        .o_status      (o_status),
        .o_count       (o_count)
    );

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_value_valid |-> o_done_res)
        else $error("result carries neither value nor done");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> (o_status == ST_OK) && (o_count == '0))
        else $error("status or count set on a value-only result");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_valid || $past(w_op_out.kind) == OP_CHAR
                  || $past(w_op_out.kind) == OP_DELIM)
        else $error("terminator consumed without a result");
`endif

endmodule

`default_nettype wire

>>> test/delimited_integer_list_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_integer_list_parser_test
// Self-checking testbench for the delimited integer list parser.
// ----------------------------------------------------------------------------
// Strings are sent one byte per transfer and a behavioural copy of the parser
// predicts every value and done result, which are checked field by field in
// order. Short directed strings cover the field rules and register corners,
// then random lists run under random register settings, random idling on
// both sides and one long receiver hold that backs the block up.
module delimited_integer_list_parser_test
    import dilp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int LONG_HOLD      = 120;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int STEADY_ITEMS   = 200;

    localparam logic [7:0]  ASC_NUL   = 8'd0;
    localparam logic [7:0]  ASC_TAB   = 8'd9;
    localparam logic [7:0]  ASC_CR    = 8'd13;
    localparam logic [7:0]  ASC_SPACE = 8'd32;
    localparam logic [7:0]  ASC_PLUS  = 8'd43;
    localparam logic [7:0]  ASC_COMMA = 8'd44;
    localparam logic [7:0]  ASC_MINUS = 8'd45;
    localparam logic [7:0]  ASC_DIG0  = 8'd48;
    localparam logic [7:0]  ASC_DIG9  = 8'd57;
    localparam logic [7:0]  ASC_SEMI  = 8'd59;
    localparam logic [12:0] ARRAY_MAX = 13'd4096;
    // largest magnitude that can still take another digit without overflow
    localparam logic [63:0] MAG_TENTH = 64'd922337203685477580;

    typedef struct packed {
        logic                value_valid;
        logic [VAL_W-1:0]    value;
        logic [IDX_W-1:0]    value_index;
        logic                done;
        t_status             status;
        logic [MAXC_W-1:0]   count;
    } t_parse_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_DELIMITER;
    logic [MAXC_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic [CH_W-1:0]      i_ch = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_value_valid;
    logic signed [VAL_W-1:0] o_value;
    logic [IDX_W-1:0]     o_value_index;
    logic                 o_done_res;
    logic [STATUS_W-1:0]  o_status;
    logic [MAXC_W-1:0]    o_count;

    delimited_integer_list_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value_valid (o_value_valid),
        .o_value       (o_value),
        .o_value_index (o_value_index),
        .o_done_res    (o_done_res),
        .o_status      (o_status),
        .o_count       (o_count)
    );

    always #2 i_clk = ~i_clk;

    // Parser copy: registers and per-string state
    logic [7:0]   delim_reg;
    logic [12:0]  capacity_reg;
    logic         cur_nonempty;
    t_phase       cur_phase;
    logic         cur_negative;
    logic [63:0]  cur_magnitude;
    logic         cur_saturated;
    logic [12:0]  values_given;
    t_status      string_status;

    t_parse_result pending_results[$];
    logic [7:0]    text_buf[$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            quiet_cycles = 0;
    int            hold_len = 0;
    bit            idling = 1'b1;

    task automatic clear_field;
        cur_nonempty  = 1'b0;
        cur_phase     = PH_SKIP;
        cur_negative  = 1'b0;
        cur_magnitude = '0;
        cur_saturated = 1'b0;
    endtask

    task automatic reset_model;
        delim_reg     = ASC_COMMA;
        capacity_reg  = 13'd16;
        values_given  = '0;
        string_status = ST_OK;
        clear_field();
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return c == ASC_SPACE || (c >= ASC_TAB && c <= ASC_CR);
    endfunction

    task automatic scan_char(input logic [7:0] c);
        if (cur_phase == PH_STOP) begin
            // rest of the field is ignored
        end else if (c >= ASC_DIG0 && c <= ASC_DIG9) begin
            cur_phase = PH_DIGITS;
            if (!cur_saturated) begin
                if (cur_magnitude > MAG_TENTH || (cur_magnitude == MAG_TENTH && c[3:0] > 4'd8))
                    cur_saturated = 1'b1;
                else
                    cur_magnitude = cur_magnitude * 64'd10 + {60'd0, c[3:0]};
            end
        end else if (cur_phase == PH_SKIP && is_blank(c)) begin
        end else if (cur_phase == PH_SKIP && (c == ASC_PLUS || c == ASC_MINUS)) begin
            cur_negative = (c == ASC_MINUS);
            cur_phase    = PH_SIGNED;
        end else begin
            cur_phase = PH_STOP;
        end
    endtask

    function automatic logic [31:0] field_value();
        if (cur_saturated || cur_magnitude[63])
            return cur_negative ? 32'd0 : 32'hFFFF_FFFF;
        return cur_negative ? 32'd0 - cur_magnitude[31:0] : cur_magnitude[31:0];
    endfunction

    task automatic close_field(output logic given, output logic [31:0] v,
                               output logic [11:0] ix);
        logic [12:0] cap;
        cap   = (capacity_reg > ARRAY_MAX) ? ARRAY_MAX : capacity_reg;
        given = 1'b0;
        v     = '0;
        ix    = '0;
        if (cur_nonempty && string_status == ST_OK) begin
            if (cap == 13'd0) begin
                string_status = ST_INVALID;
            end else if (values_given >= cap) begin
                string_status = ST_OVERFLOW;
            end else begin
                v     = field_value();
                ix    = values_given[11:0];
                values_given = values_given + 13'd1;
                given = 1'b1;
            end
        end
        clear_field();
    endtask

    task automatic predict_char(input logic [7:0] c);
        t_parse_result r;
        logic          given;
        logic [31:0]   v;
        logic [11:0]   ix;
        r = '0;
        if (c == ASC_NUL) begin
            close_field(given, v, ix);
            if (string_status == ST_OK && capacity_reg == 13'd0)
                string_status = ST_INVALID;
            r.value_valid = given;
            r.value       = v;
            r.value_index = ix;
            r.done        = 1'b1;
            r.status      = string_status;
            r.count       = values_given;
            pending_results.push_back(r);
            values_given  = '0;
            string_status = ST_OK;
            clear_field();
        end else if (string_status != ST_OK) begin
            // bytes after an error are dropped until the terminator
        end else if (c == delim_reg) begin
            close_field(given, v, ix);
            if (given) begin
                r.value_valid = 1'b1;
                r.value       = v;
                r.value_index = ix;
                pending_results.push_back(r);
            end
        end else begin
            cur_nonempty = 1'b1;
            scan_char(c);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        if (idling && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        items_sent++;
        predict_char(c);
    endtask

    task automatic send_text;
        while (text_buf.size() > 0)
            send_char(text_buf.pop_front());
    endtask

    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] delim, input logic [12:0] cap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_DELIMITER;
        i_cfg_data <= {5'd0, delim};
        @(posedge i_clk);
        delim_reg = delim;
        i_cfg_idx  <= REG_MAX_COUNT;
        i_cfg_data <= cap;
        @(posedge i_clk);
        capacity_reg = cap;
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        logic [31:0] r;
        r = $urandom_range(lo, hi);
        return r[7:0];
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] b;
        b = rand_byte(8, 13);
        return (b == 8'd8) ? ASC_SPACE : b;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic add_decimal(input logic [63:0] v);
        logic [7:0]  digits[$];
        logic [63:0] rest;
        logic [63:0] d;
        rest = v;
        do begin
            d = rest % 64'd10;
            digits.push_front(ASC_DIG0 + d[7:0]);
            rest = rest / 64'd10;
        end while (rest != 0);
        foreach (digits[i])
            text_buf.push_back(digits[i]);
    endtask

    task automatic add_field;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) text_buf.push_back(rand_byte(1, 255));
        end else begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(blank_byte());
            case ($urandom_range(0, 5))
                0: text_buf.push_back(ASC_MINUS);
                1: text_buf.push_back(ASC_PLUS);
                default: ;
            endcase
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(ASC_DIG0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_decimal($urandom_range(0, 999));
                4, 5:       add_decimal($urandom);
                6:          add_decimal({$urandom, $urandom});
                7: begin
                    // straddle the saturation point
                    add_decimal(MAG_TENTH);
                    text_buf.push_back(rand_byte(55, 57));
                    if ($urandom_range(0, 2) == 0) text_buf.push_back(rand_byte(48, 57));
                end
                8:       ;
                default: add_decimal($urandom_range(0, 99));
            endcase
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(rand_byte(1, 255));
        end
    endtask

    task automatic add_list;
        int nfields;
        nfields = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0) text_buf.push_back(delim_reg);
        for (int i = 0; i < nfields; i++) begin
            add_field();
            if (i < nfields - 1 || $urandom_range(0, 3) == 0) text_buf.push_back(delim_reg);
            if ($urandom_range(0, 7) == 0) text_buf.push_back(delim_reg);
        end
        text_buf.push_back(ASC_NUL);
    endtask

    function automatic logic [7:0] pick_delimiter();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return ASC_COMMA;
            5:             return ASC_SPACE;
            6:             return ASC_SEMI;
            7:             return ($urandom_range(0, 1) == 0) ? ASC_NUL : 8'hFF;
            8:             return ($urandom_range(0, 1) == 0) ? ASC_MINUS : rand_byte(48, 57);
            default:       return rand_byte(0, 255);
        endcase
    endfunction

    function automatic logic [12:0] pick_capacity();
        logic [31:0] r;
        case ($urandom_range(0, 9))
            0:             r = 0;
            1, 2, 3, 4, 5: r = $urandom_range(1, 8);
            6:             r = 16;
            7:             r = ARRAY_MAX;
            8:             r = ($urandom_range(0, 1) == 0) ? 8191 : 4097;
            default:       r = $urandom_range(0, 4096);
        endcase
        return r[12:0];
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset registers: blanks, signs, junk after digits, empty fields, high byte
    task automatic test_field_rules;
        push_text(",\t-8x,,+");
        text_buf.push_back(8'hFF);
        push_text(",");
        text_buf.push_back(ASC_NUL);
        send_text();
        drain_results();
    endtask

    // Digit delimiter, array full on the second field, trailing bytes dropped
    task automatic test_full_array;
        configure(ASC_DIG0 + 8'd5, 13'd1);
        push_text("15257");
        text_buf.push_back(ASC_NUL);
        send_text();
        drain_results();
    endtask

    // Zero delimiter and zero capacity, with and without a field
    task automatic test_zero_capacity;
        configure(ASC_NUL, 13'd0);
        text_buf.push_back(ASC_NUL);
        push_text("7");
        text_buf.push_back(ASC_NUL);
        send_text();
        drain_results();
    endtask

    // Capacity register beyond the array limit, blank delimiter
    task automatic test_wide_capacity;
        configure(ASC_SPACE, 13'h1FFF);
        push_text(" 4 -");
        text_buf.push_back(ASC_NUL);
        send_text();
        drain_results();
    endtask

    task automatic test_random_lists;
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            configure(pick_delimiter(), pick_capacity());
            idling = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5)) begin
                add_list();
                send_text();
            end
            drain_results();
        end
        idling = 1'b1;
    endtask

    // Receiver holds off long enough for the input side to back up
    task automatic test_backpressure;
        configure(8'hFF, ARRAY_MAX);
        hold_len = LONG_HOLD;
        for (int k = 0; k < 20; k++) begin
            add_decimal(k * 37);
            text_buf.push_back(8'hFF);
        end
        text_buf.push_back(ASC_NUL);
        send_text();
        drain_results();
    endtask

    task automatic test_steady_stream;
        int stop_at;
        idling = 1'b0;
        configure(ASC_COMMA, 13'd8);
        stop_at = items_sent + STEADY_ITEMS;
        while (items_sent < stop_at) begin
            add_list();
            send_text();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                i_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_stall <= 1'b0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_parse_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected transfer", 64'd0, {32'd0, o_value});
            end else begin
                want = pending_results.pop_front();
                if (o_value_valid !== want.value_valid)
                    note_mismatch("value_valid", want.value_valid, o_value_valid);
                if (o_value !== want.value)
                    note_mismatch("value", want.value, o_value);
                if (o_value_index !== want.value_index)
                    note_mismatch("value_index", want.value_index, o_value_index);
                if (o_done_res !== want.done)
                    note_mismatch("done_res", want.done, o_done_res);
                if (o_status !== want.status)
                    note_mismatch("status", want.status, o_status);
                if (o_count !== want.count)
                    note_mismatch("count", want.count, o_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_rules();
        test_full_array();
        test_zero_capacity();
        test_wide_capacity();
        test_random_lists();
        test_backpressure();
        test_steady_stream();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/dilp_pkg.sv
rtl/core/dilp_front.sv
rtl/core/dilp_queue.sv
rtl/core/dilp_back.sv
rtl/core/delimited_integer_list_parser.sv
test/delimited_integer_list_parser_test.sv
